FILE: rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Expects signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
// No dependencies; every allocator file except assert_macros.svh imports this package.
package ffba_pkg;

   localparam int MAX_BLOCKS_DEFAULT = 64;
   localparam int HEADER_BYTES       = 24;
   localparam int WORD_BYTES         = 8;    // power of two
   localparam int REG_WIDTH          = 32;
   localparam int CSR_INDEX_WIDTH    = 1;

   localparam logic [REG_WIDTH-1:0] HEAP_BASE_RESET  = 32'd4096;
   localparam logic [REG_WIDTH-1:0] HEAP_LIMIT_RESET = 32'd65536;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEAP_BASE  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEAP_LIMIT = 1'd1;

   typedef enum logic {
      CMD_ALLOCATE = 1'b0,
      CMD_RELEASE  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK              = 2'd0,
      STATUS_NO_SPACE        = 2'd1,
      STATUS_NULL_POINTER    = 2'd2,
      STATUS_UNKNOWN_POINTER = 2'd3
   } status_type;

   typedef struct packed {
      command_type command;
      logic [31:0] request_bytes;
      logic [31:0] release_address;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] data_address;
      status_type  status;
      logic        reused;
   } rsp_payload_type;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] size;
      logic        free;
   } entry_type;

   typedef enum logic [1:0] {
      FSM_IDLE   = 2'd0,
      FSM_SCAN   = 2'd1,
      FSM_DECIDE = 2'd2
   } fsm_state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic slot_free;
   } ctrl_status_type;

endpackage

FILE: rtl/ffba_channels.sv
// Valid/ready channel interfaces for allocator requests and responses.
// Depends on ffba_pkg for the payload types.
interface ffba_req_if;
   import ffba_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ffba_rsp_if;
   import ffba_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/ffba_controller.sv
// Sequencer of the allocator: accept, table scan, commit.
// Depends on ffba_pkg; drives the datapath through ctrl_cmd_type.
module ffba_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ffba_pkg::ctrl_status_type status,
   output ffba_pkg::ctrl_cmd_type    cmd
);
   import ffba_pkg::*;

   fsm_state_type state_ff;
   fsm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = FSM_DECIDE;
            end
         end
         FSM_DECIDE: begin
            if (status.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/ffba_datapath.sv
// Block table memory, scan pipeline, heap registers and response register.
// Depends on ffba_pkg and assert_macros.svh; sequenced by ffba_controller.
module ffba_datapath #(
   parameter int MaxBlocks = ffba_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ffba_pkg::ctrl_cmd_type                   cmd,
   output ffba_pkg::ctrl_status_type                status,
   input  ffba_pkg::req_payload_type                req_payload,
   input  logic                                    csr_write_enable,
   input  logic [ffba_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [ffba_pkg::REG_WIDTH-1:0]           csr_write_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output ffba_pkg::rsp_payload_type                rsp_payload
);
   import ffba_pkg::*;
`include "assert_macros.svh"

   localparam int CountWidth = $clog2(MaxBlocks + 1);
   localparam int IndexWidth = $clog2(MaxBlocks);
   localparam logic [32:0] RoundAdd  = 33'(WORD_BYTES - 1);
   localparam logic [32:0] RoundMask = ~RoundAdd;
   localparam logic [31:0] Header32  = 32'(HEADER_BYTES);
   localparam logic [33:0] Header34  = 34'(HEADER_BYTES);

   entry_type entry_mem [MaxBlocks];

   logic [REG_WIDTH-1:0]  base_ff, base_in;
   logic [REG_WIDTH-1:0]  limit_ff, limit_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [31:0]           top_ff, top_in;
   logic [CountWidth-1:0] rd_idx_ff, rd_idx_in;
   logic                  chk_valid_ff, chk_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   command_type           cmd_type_ff, cmd_type_in;
   logic [32:0]           rounded_ff, rounded_in;
   logic [31:0]           target_ff, target_in;
   logic                  addr_null_ff, addr_null_in;
   logic [31:0]           base_hdr_ff, base_hdr_in;
   logic [33:0]           end_ff, end_in;
   logic [IndexWidth-1:0] chk_idx_ff, chk_idx_in;
   logic                  found_ff, found_in;
   logic [IndexWidth-1:0] hit_idx_ff, hit_idx_in;
   entry_type             hit_entry_ff, hit_entry_in;
   rsp_payload_type       rsp_payload_ff, rsp_payload_in;
   entry_type             rd_entry_ff;

   logic                  rd_active;
   logic                  is_alloc;
   logic                  chk_match;
   logic                  take_hit;
   logic                  table_full;
   logic                  over_limit;
   logic                  hit_is_last;
   logic                  mem_we;
   logic [IndexWidth-1:0] mem_waddr;
   entry_type             mem_wdata;

   assign rd_active   = rd_idx_ff < count_ff;
   assign is_alloc    = cmd_type_ff == CMD_ALLOCATE;
   assign chk_match   = chk_valid_ff &&
                        (is_alloc ? (rd_entry_ff.free && ({1'b0, rd_entry_ff.size} >= rounded_ff))
                                  : (rd_entry_ff.start == target_ff));
   assign take_hit    = chk_match && !(is_alloc && found_ff);
   assign table_full  = count_ff == CountWidth'(MaxBlocks);
   assign over_limit  = end_ff > {2'b00, limit_ff};
   assign hit_is_last = (CountWidth'(hit_idx_ff) + CountWidth'(1)) == count_ff;

   assign status.scan_done = (!rd_active && !chk_valid_ff) || (is_alloc && found_ff);
   assign status.slot_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      base_in        = base_ff;
      limit_in       = limit_ff;
      count_in       = count_ff;
      top_in         = top_ff;
      rd_idx_in      = rd_idx_ff;
      chk_valid_in   = chk_valid_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      cmd_type_in    = cmd_type_ff;
      rounded_in     = rounded_ff;
      target_in      = target_ff;
      addr_null_in   = addr_null_ff;
      base_hdr_in    = base_hdr_ff;
      end_in         = {2'b00, top_ff} + Header34 + {1'b0, rounded_ff};
      chk_idx_in     = chk_idx_ff;
      found_in       = found_ff;
      hit_idx_in     = hit_idx_ff;
      hit_entry_in   = hit_entry_ff;
      rsp_payload_in = rsp_payload_ff;
      mem_we         = 1'b0;
      mem_waddr      = hit_idx_ff;
      mem_wdata      = hit_entry_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_HEAP_BASE:  base_in  = csr_write_data;
            CSR_HEAP_LIMIT: limit_in = csr_write_data;
            default: ;
         endcase
      end

      if (cmd.load) begin
         cmd_type_in  = req_payload.command;
         rounded_in   = ({1'b0, req_payload.request_bytes} + RoundAdd) & RoundMask;
         target_in    = req_payload.release_address - base_ff - Header32;
         addr_null_in = req_payload.release_address == '0;
         base_hdr_in  = base_ff + Header32;
         rd_idx_in    = '0;
         chk_valid_in = 1'b0;
         found_in     = 1'b0;
      end

      if (cmd.scan) begin
         if (rd_active) begin
            rd_idx_in = rd_idx_ff + CountWidth'(1);
         end
         chk_valid_in = rd_active;
         chk_idx_in   = rd_idx_ff[IndexWidth-1:0];
         if (take_hit) begin
            found_in     = 1'b1;
            hit_idx_in   = chk_idx_ff;
            hit_entry_in = rd_entry_ff;
         end
      end

      if (cmd.commit) begin
         rsp_valid_in                = 1'b1;
         rsp_payload_in.data_address = '0;
         rsp_payload_in.status       = STATUS_OK;
         rsp_payload_in.reused       = 1'b0;
         if (is_alloc) begin
            if (found_ff) begin
               mem_we                      = 1'b1;
               mem_wdata.free              = 1'b0;
               rsp_payload_in.data_address = base_hdr_ff + hit_entry_ff.start;
               rsp_payload_in.reused       = 1'b1;
            end else if (table_full || over_limit) begin
               rsp_payload_in.status = STATUS_NO_SPACE;
            end else begin
               mem_we                      = 1'b1;
               mem_waddr                   = count_ff[IndexWidth-1:0];
               mem_wdata.start             = top_ff;
               mem_wdata.size              = rounded_ff[31:0];
               mem_wdata.free              = 1'b0;
               count_in                    = count_ff + CountWidth'(1);
               top_in                      = end_ff[31:0];
               rsp_payload_in.data_address = base_hdr_ff + top_ff;
            end
         end else if (addr_null_ff) begin
            rsp_payload_in.status = STATUS_NULL_POINTER;
         end else if (!found_ff) begin
            rsp_payload_in.status = STATUS_UNKNOWN_POINTER;
         end else if (hit_is_last) begin
            top_in   = hit_entry_ff.start;
            count_in = CountWidth'(hit_idx_ff);
         end else begin
            mem_we         = 1'b1;
            mem_wdata.free = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= HEAP_BASE_RESET;
         limit_ff     <= HEAP_LIMIT_RESET;
         count_ff     <= '0;
         top_ff       <= '0;
         rd_idx_ff    <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         limit_ff     <= limit_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         rd_idx_ff    <= rd_idx_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_type_ff    <= cmd_type_in;
      rounded_ff     <= rounded_in;
      target_ff      <= target_in;
      addr_null_ff   <= addr_null_in;
      base_hdr_ff    <= base_hdr_in;
      end_ff         <= end_in;
      chk_idx_ff     <= chk_idx_in;
      found_ff       <= found_in;
      hit_idx_ff     <= hit_idx_in;
      hit_entry_ff   <= hit_entry_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.scan && rd_active) begin
         rd_entry_ff <= entry_mem[rd_idx_ff[IndexWidth-1:0]];
      end
   end

   `ASSERT_CLK(a_count_bound, count_ff <= CountWidth'(MaxBlocks), "entry count above table depth")
   `ASSERT_CLK(a_empty_top, (count_ff == '0) |-> (top_ff == '0), "empty table with nonzero top")
   `ASSERT_CLK(a_commit_slot, cmd.commit |-> status.slot_free, "commit while response slot busy")
   `ASSERT_NEXT(a_scan_after_load, cmd.load, !chk_valid_ff && (rd_idx_ff == '0), "scan not rewound")

endmodule

FILE: rtl/first_fit_block_allocator_unit.sv
// First-fit block allocator. An item allocates (first free block that is large enough, else a
// new block appended at the heap top) or releases a block by its data address, and yields one
// response item. The unit accepts the item, then reads the single-port block table memory
// one table entry per cycle; the registered read and the last compare then drain, and a final
// step updates and posts the response. An allocate scans only up to the entry that fits. The
// update waits while the previous response item still sits unaccepted in the output register;
// the next item is accepted right after the update. heap_base (index 0) and heap_limit
// (index 1) are written through the csr port; the user must write them only while idle,
// as the block itself does not enforce this.
module first_fit_block_allocator_unit #(
   parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   ffba_req_if.sink                            req_channel,
   ffba_rsp_if.source                          rsp_channel,
   input  logic                                csr_write_enable,
   input  logic [ffba_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ffba_pkg::REG_WIDTH-1:0]       csr_write_data
);
   import ffba_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   ffba_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_channel.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ffba_datapath #(
      .MaxBlocks (MAX_BLOCKS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_payload      (req_channel.payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_channel.valid),
      .rsp_ready        (rsp_channel.ready),
      .rsp_payload      (rsp_channel.payload)
   );

endmodule
